// File: design/ccfr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccfr_pkg: shared types and constants of the COBS/CRC frame receiver
// Frame limits, the controller state type, and the command and status
// bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ccfr_pkg;

    localparam int MAX_PAYLOAD   = 32;
    localparam int MAX_ENCODED   = 38;
    localparam int HDR_BYTES     = 3;
    localparam int HDR_CRC_BYTES = 5;
    localparam int ENC_AW        = $clog2(MAX_ENCODED);
    localparam int CNT_W         = $clog2(MAX_ENCODED + 1);

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DECODE,
        ST_CHECK,
        ST_STATUS,
        ST_PAYLOAD
    } t_state;

    typedef struct packed {
        logic collect;
        logic decode;
        logic check;
        logic emit_status;
        logic emit_payload;
    } t_ctl_cmd;

    typedef struct packed {
        logic close_frame;
        logic decode_done;
        logic last_item;
    } t_dp_status;

endpackage
`default_nettype wire

// File: design/cobs_crc_frame_receiver.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cobs_crc_frame_receiver: COBS deframer with CRC-16/CCITT-FALSE check
// Top level: sequencer, datapath, and checks on the result channel.
// ---------------------------------------------------------------------------
// Received bytes are taken one per cycle while the block is collecting. A zero
// byte opens a frame, later non-zero bytes are stored (up to 38, the rest are
// dropped and the frame is marked bad), and a zero after at least one stored
// byte closes it. On the closing byte the input stalls while the stored frame
// is read back one byte a cycle through the COBS decoder, which feeds a
// bytewise CRC-16 (poly 0x1021, init 0xFFFF) lagging two bytes so that the
// final two decoded bytes serve as the little-endian check word. The input
// stays stalled through the memory reads, the pipeline fill and the check
// state, then one status item is offered with packet type, data type and
// length; a good frame with a non-zero length follows with one payload item
// per cycle while the result side does not stall, each tagged with its index,
// the final item of a frame carrying last_item. Input resumes in the cycle
// after the last result item is taken. Frames that are overlong, carry
// malformed COBS, decode to fewer than five bytes, declare a length over 32
// or beyond the decoded bytes, or fail the CRC give the status item only,
// marked bad.
// ---------------------------------------------------------------------------
module cobs_crc_frame_receiver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic            o_item_kind,
    output logic            o_frame_good,
    output logic [7:0]      o_packet_type,
    output logic [7:0]      o_data_type,
    output logic [5:0]      o_data_length,
    output logic [7:0]      o_payload_byte,
    output logic [4:0]      o_payload_index,
    output logic            o_last_item
);
    import ccfr_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;
    logic       in_acc;
    logic       out_acc;

    // handshakes complete when valid is up and the far side does not hold off
    assign in_acc  = i_rx_valid && !o_rx_stall;
    assign out_acc = o_res_valid && !i_res_stall;

    ccfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (status),
        .i_out_acc   (out_acc),
        .o_cmd       (cmd),
        .o_rx_stall  (o_rx_stall),
        .o_res_valid (o_res_valid)
    );

    ccfr_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_in_acc        (in_acc),
        .i_rx_byte       (i_rx_byte),
        .i_out_acc       (out_acc),
        .o_status        (status),
        .o_item_kind     (o_item_kind),
        .o_frame_good    (o_frame_good),
        .o_packet_type   (o_packet_type),
        .o_data_type     (o_data_type),
        .o_data_length   (o_data_length),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index)
    );

    // last_item is only meaningful while a result is offered
    assign o_last_item = o_res_valid && status.last_item;

    // no byte is taken while results are being offered
    a_no_rx_during_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_rx_stall)
        else $error("input accepted while results pending");

    // payload items only follow a good frame
    a_payload_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_item_kind) |-> o_frame_good)
        else $error("payload item on bad frame");

    // after the final item is taken the result channel goes quiet
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_item) |=> !o_res_valid)
        else $error("result offered after last item");

    // payload index advances by one between consecutive payload items
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_item_kind && !o_last_item)
        |=> (o_res_valid && o_item_kind
             && (o_payload_index == 5'($past(o_payload_index) + 5'd1))))
        else $error("payload index skipped");

endmodule
`default_nettype wire

// File: design/ccfr_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccfr_ctrl: frame receiver sequencer
// Collects bytes, then runs decode, check and result emission in turn.
// ---------------------------------------------------------------------------
module ccfr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ccfr_pkg::t_dp_status i_status,
    input  wire logic                 i_out_acc,
    output ccfr_pkg::t_ctl_cmd        o_cmd,
    output logic                      o_rx_stall,
    output logic                      o_res_valid
);
    import ccfr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (i_status.close_frame) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.decode_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_STATUS;
            end
            ST_STATUS: begin
                if (i_out_acc) begin
                    n_state = i_status.last_item ? ST_COLLECT : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (i_out_acc && i_status.last_item) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_rx_stall  = 1'b1;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                o_cmd.collect = 1'b1;
                o_rx_stall    = 1'b0;
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            ST_STATUS: begin
                o_cmd.emit_status = 1'b1;
                o_res_valid       = 1'b1;
            end
            ST_PAYLOAD: begin
                o_cmd.emit_payload = 1'b1;
                o_res_valid        = 1'b1;
            end
            default: begin
                o_rx_stall = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/ccfr_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccfr_dpath: frame receiver datapath
// Encoded byte store, streaming COBS decoder with running CRC, decoded byte
// store and result field registers.
// ---------------------------------------------------------------------------
module ccfr_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ccfr_pkg::t_ctl_cmd i_cmd,
    input  wire logic               i_in_acc,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_out_acc,
    output ccfr_pkg::t_dp_status    o_status,
    output logic                    o_item_kind,
    output logic                    o_frame_good,
    output logic [7:0]              o_packet_type,
    output logic [7:0]              o_data_type,
    output logic [5:0]              o_data_length,
    output logic [7:0]              o_payload_byte,
    output logic [4:0]              o_payload_index
);
    import ccfr_pkg::*;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] x;
        x = crc ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        end
        return x;
    endfunction

    logic [7:0] enc_mem [MAX_ENCODED];
    logic [7:0] dec_mem [MAX_ENCODED];

    // collection
    logic             r_in_frame;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    // decode
    logic [CNT_W-1:0] r_rd_ptr;
    logic             r_pvalid;
    logic [CNT_W-1:0] r_ppos;
    logic [7:0]       r_enc_q;
    logic [7:0]       r_rem;
    logic [7:0]       r_code;
    logic             r_first;
    logic             r_err;
    logic [CNT_W-1:0] r_n;
    logic [15:0]      r_crc;
    logic [7:0]       r_tail0;
    logic [7:0]       r_tail1;
    logic [7:0]       r_pt;
    logic [7:0]       r_dt;
    logic [7:0]       r_len;
    // results
    logic             r_good;
    logic [4:0]       r_pidx;
    logic [7:0]       r_dec_q;

    logic             close_frame;
    logic             store_byte;
    logic             issue;
    logic             proc;
    logic             code_bad;
    logic             err_now;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             good_c;
    logic [4:0]       n_pidx;
    logic [ENC_AW-1:0] dec_raddr;

    assign close_frame = i_in_acc && r_in_frame && (i_rx_byte == 8'h00) && (r_cnt != '0);
    assign store_byte  = i_in_acc && r_in_frame && (i_rx_byte != 8'h00)
                         && (r_cnt < CNT_W'(MAX_ENCODED));
    assign issue       = i_cmd.decode && (r_rd_ptr < r_cnt);
    assign proc        = i_cmd.decode && r_pvalid && !r_err;
    assign code_bad    = (r_enc_q == 8'h00)
                         || (({3'b000, r_ppos} + {1'b0, r_enc_q}) > {3'b000, r_cnt});

    always_comb begin
        emit      = 1'b0;
        emit_byte = r_enc_q;
        err_now   = 1'b0;
        if (proc) begin
            if (r_rem == 8'h00) begin
                if (code_bad) begin
                    err_now = 1'b1;
                end else if (!r_first && (r_code != 8'hFF)) begin
                    // previous block ended short: its implied zero comes now
                    emit      = 1'b1;
                    emit_byte = 8'h00;
                end
            end else begin
                emit = 1'b1;
            end
        end
    end

    assign good_c = !r_ovf && !r_err
                    && (r_n >= CNT_W'(HDR_CRC_BYTES))
                    && (r_len <= 8'(MAX_PAYLOAD))
                    && (({1'b0, r_len} + 9'(HDR_CRC_BYTES)) <= {3'b000, r_n})
                    && (r_crc == {r_tail1, r_tail0});

    assign n_pidx    = (i_cmd.emit_payload && i_out_acc) ? (r_pidx + 5'd1) : r_pidx;
    assign dec_raddr = ENC_AW'(HDR_BYTES) + ENC_AW'(n_pidx);

    always_ff @(posedge i_clk) begin
        if (store_byte) begin
            enc_mem[r_cnt[ENC_AW-1:0]] <= i_rx_byte;
        end
        if (issue) begin
            r_enc_q <= enc_mem[r_rd_ptr[ENC_AW-1:0]];
        end
        if (emit) begin
            dec_mem[r_n[ENC_AW-1:0]] <= emit_byte;
        end
        r_dec_q <= dec_mem[dec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_pvalid   <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            if (i_in_acc) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == 8'h00) begin
                        r_in_frame <= 1'b1;
                        r_cnt      <= '0;
                        r_ovf      <= 1'b0;
                    end
                end else if (i_rx_byte != 8'h00) begin
                    if (store_byte) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end else if (close_frame) begin
                    r_in_frame <= 1'b0;
                end
            end

            if (close_frame) begin
                r_rd_ptr <= '0;
                r_pvalid <= 1'b0;
                r_rem    <= 8'h00;
                r_code   <= 8'h00;
                r_first  <= 1'b1;
                r_err    <= 1'b0;
                r_n      <= '0;
                r_crc    <= CRC_INIT;
                r_pt     <= 8'h00;
                r_dt     <= 8'h00;
                r_len    <= 8'h00;
            end else begin
                if (issue) begin
                    r_rd_ptr <= r_rd_ptr + CNT_W'(1);
                end
                r_pvalid <= issue;
                r_ppos   <= r_rd_ptr;
                if (err_now) begin
                    r_err <= 1'b1;
                end
                if (proc) begin
                    if (r_rem == 8'h00) begin
                        if (!code_bad) begin
                            r_rem   <= r_enc_q - 8'd1;
                            r_code  <= r_enc_q;
                            r_first <= 1'b0;
                        end
                    end else begin
                        r_rem <= r_rem - 8'd1;
                    end
                end
                if (emit) begin
                    // CRC trails by two bytes: the last two end up as the check word
                    if (r_n >= CNT_W'(2)) begin
                        r_crc <= f_crc_byte(r_crc, r_tail0);
                    end
                    r_tail0 <= r_tail1;
                    r_tail1 <= emit_byte;
                    r_n     <= r_n + CNT_W'(1);
                    if (r_n == CNT_W'(0)) begin
                        r_pt <= emit_byte;
                    end
                    if (r_n == CNT_W'(1)) begin
                        r_dt <= emit_byte;
                    end
                    if (r_n == CNT_W'(2)) begin
                        r_len <= emit_byte;
                    end
                end
                if (i_cmd.check) begin
                    r_good <= good_c;
                    r_pidx <= '0;
                    if (r_err) begin
                        r_pt  <= 8'h00;
                        r_dt  <= 8'h00;
                        r_len <= 8'h00;
                    end
                end else begin
                    r_pidx <= n_pidx;
                end
            end
        end
    end

    assign o_status.close_frame = close_frame;
    assign o_status.decode_done = proc && (err_now || (r_ppos == (r_cnt - CNT_W'(1))));
    assign o_status.last_item   = i_cmd.emit_payload
                                  ? (({3'b000, r_pidx} + 8'd1) == r_len)
                                  : (!r_good || (r_len == 8'h00));

    assign o_item_kind     = i_cmd.emit_payload;
    assign o_frame_good    = r_good;
    assign o_packet_type   = r_pt;
    assign o_data_type     = r_dt;
    assign o_data_length   = (r_len > 8'd63) ? 6'h3F : r_len[5:0];
    assign o_payload_byte  = i_cmd.emit_payload ? r_dec_q : 8'h00;
    assign o_payload_index = i_cmd.emit_payload ? r_pidx : 5'd0;

endmodule
`default_nettype wire

// File: verif/cobs_crc_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cobs_crc_frame_receiver_tb: self-checking bench for the COBS/CRC receiver
// Feeds serial bytes through the valid/stall input channel and checks every
// result item against a behavioral deframer in the bench or against a status
// item from a short directed table of corner cases. Random frames follow, mostly
// well formed with random content, mixed with noise, broken and overlong frames.
// ---------------------------------------------------------------------------
module cobs_crc_frame_receiver_tb;

    import ccfr_pkg::MAX_PAYLOAD;
    import ccfr_pkg::MAX_ENCODED;
    import ccfr_pkg::HDR_BYTES;
    import ccfr_pkg::HDR_CRC_BYTES;

    localparam bit [7:0]    FRAME_DELIM  = 8'h00;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    localparam int          ITEM_TARGET  = 400;
    localparam int          HOLD_CYCLES  = 400;

    // One result item as the block presents it.
    typedef struct packed {
        bit       kind;
        bit       good;
        bit [7:0] ptype;
        bit [7:0] dtype;
        bit [5:0] dlen;
        bit [7:0] pbyte;
        bit [4:0] pidx;
        bit       last;
    } rx_result_t;

    typedef rx_result_t rx_result_q_t [$];
    typedef bit [7:0]   byte_q_t [$];

    // How a directed row is checked: by the deframer below, by "nothing
    // comes out", or by a status item written into the table.
    typedef enum bit [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_STATUS
    } row_chk_t;

    typedef struct packed {
        bit [7:0]   rx;
        row_chk_t   chk;
        rx_result_t want;
    } dir_row_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_res_valid;
    logic       o_item_kind;
    logic       o_frame_good;
    logic [7:0] o_packet_type;
    logic [7:0] o_data_type;
    logic [5:0] o_data_length;
    logic [7:0] o_payload_byte;
    logic [4:0] o_payload_index;
    logic       o_last_item;

    // Deframer state, mirrored from the block.
    bit          rx_open;
    int unsigned enc_cnt;
    bit          enc_over;
    bit [7:0]    enc_mem [MAX_ENCODED];

    rx_result_t pending_items [$];
    dir_row_t   dir_rows [$];
    int         mismatches   = 0;
    int         results_seen = 0;
    bit         no_idle      = 1'b0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;

    cobs_crc_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_item_kind    (o_item_kind),
        .o_frame_good   (o_frame_good),
        .o_packet_type  (o_packet_type),
        .o_data_type    (o_data_type),
        .o_data_length  (o_data_length),
        .o_payload_byte (o_payload_byte),
        .o_payload_index(o_payload_index),
        .o_last_item    (o_last_item)
    );

    always #6 i_clk = ~i_clk;

    // CRC-16/CCITT-FALSE over the first len bytes: MSB first, init all ones.
    function automatic bit [15:0] crc16_ccitt(input byte_q_t d, input int unsigned len);
        bit [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < len; i++) begin
            c ^= {d[i], 8'h00};
            for (int j = 0; j < 8; j++) begin
                c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
            end
        end
        return c;
    endfunction

    // Advance the deframer by one accepted byte and return the items it causes.
    function automatic void deframe_step(input bit [7:0] b, output rx_result_q_t items);
        byte_q_t     dec;
        int unsigned pos;
        int unsigned code;
        int unsigned plen;
        bit          ok;
        bit          good;
        rx_result_t  r;
        items = {};
        if (!rx_open) begin
            // Ignore anything but a delimiter while waiting for a frame.
            if (b == FRAME_DELIM) begin
                rx_open  = 1'b1;
                enc_cnt  = 0;
                enc_over = 1'b0;
            end
            return;
        end
        if (b != FRAME_DELIM) begin
            // Store up to the limit, then drop and remember the overflow.
            if (enc_cnt < MAX_ENCODED) begin
                enc_mem[enc_cnt] = b;
                enc_cnt++;
            end else begin
                enc_over = 1'b1;
            end
            return;
        end
        // A delimiter with nothing stored leaves the frame open.
        if (enc_cnt == 0) return;
        rx_open = 1'b0;

        // Undo the COBS: each code byte announces code-1 data bytes and,
        // unless it is the maximal code or the frame ends, one zero.
        pos = 0;
        ok  = 1'b1;
        while (ok && pos < enc_cnt) begin
            code = enc_mem[pos];
            if (code == 0 || pos + code > enc_cnt) begin
                ok = 1'b0;
            end else begin
                for (int k = 1; k < code; k++) begin
                    if (dec.size() < MAX_ENCODED) dec.push_back(enc_mem[pos + k]);
                end
                pos += code;
                if (code != 255 && pos < enc_cnt && dec.size() < MAX_ENCODED) begin
                    dec.push_back(8'h00);
                end
            end
        end
        if (!ok) dec = {};
        good = ok && !enc_over;

        // Header fields read as zero when the frame is too short to hold them.
        r    = '0;
        plen = 0;
        if (dec.size() >= 1) r.ptype = dec[0];
        if (dec.size() >= 2) r.dtype = dec[1];
        if (dec.size() >= 3) begin
            plen   = dec[2];
            r.dlen = (plen > 63) ? 6'd63 : plen[5:0];
        end
        if (dec.size() < HDR_CRC_BYTES || plen > MAX_PAYLOAD ||
            plen + HDR_CRC_BYTES > dec.size()) begin
            good = 1'b0;
        end else if (crc16_ccitt(dec, dec.size() - 2) !=
                     {dec[dec.size() - 1], dec[dec.size() - 2]}) begin
            good = 1'b0;
        end
        r.good = good;

        // Bad or payload-free frames end on the status item.
        if (!good || plen == 0) begin
            r.last = 1'b1;
            items.push_back(r);
            return;
        end
        items.push_back(r);
        r.kind = 1'b1;
        for (int i = 0; i < plen; i++) begin
            r.pbyte = dec[HDR_BYTES + i];
            r.pidx  = i[4:0];
            r.last  = (i + 1 == plen);
            items.push_back(r);
        end
    endfunction

    // Standard COBS encoding; frames here stay far below the 254-byte run.
    function automatic byte_q_t cobs_wrap(input byte_q_t raw);
        byte_q_t     enc;
        int unsigned cpos;
        bit [7:0]    code;
        enc.push_back(8'h00);
        cpos = 0;
        code = 8'h01;
        foreach (raw[j]) begin
            if (raw[j] == 8'h00) begin
                enc[cpos] = code;
                cpos      = enc.size();
                enc.push_back(8'h00);
                code      = 8'h01;
            end else begin
                enc.push_back(raw[j]);
                code++;
            end
        end
        enc[cpos] = code;
        return enc;
    endfunction

    // Header, payload and little-endian CRC; optionally spoil the CRC.
    function automatic byte_q_t build_frame(input bit [7:0] pt, input bit [7:0] dt,
                                            input bit [7:0] lenf, input byte_q_t pay,
                                            input bit spoil);
        byte_q_t   raw;
        bit [15:0] c;
        raw = {pt, dt, lenf};
        foreach (pay[j]) raw.push_back(pay[j]);
        c = crc16_ccitt(raw, raw.size());
        raw.push_back(c[7:0]);
        raw.push_back(c[15:8]);
        if (spoil) raw[raw.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        return raw;
    endfunction

    // Payload bytes with plenty of zeros, so the COBS codes get exercised.
    function automatic byte_q_t rand_payload(input int unsigned n);
        byte_q_t pay;
        repeat (n) pay.push_back(($urandom_range(0, 4) == 0) ? 8'h00 :
                                 8'($urandom_range(0, 255)));
        return pay;
    endfunction

    function automatic rx_result_t status_item(input bit good, input bit [7:0] pt,
                                               input bit [7:0] dt, input bit [5:0] dl);
        rx_result_t s;
        s       = '0;
        s.good  = good;
        s.ptype = pt;
        s.dtype = dt;
        s.dlen  = dl;
        s.last  = 1'b1;
        return s;
    endfunction

    function automatic void add_row(input bit [7:0] rx, input row_chk_t chk,
                                    input rx_result_t want);
        dir_row_t row;
        row.rx   = rx;
        row.chk  = chk;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void check_field(input string fname, input bit [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    // Offer one byte and hold it until the block takes it. Idle at random
    // before the offer, never in reaction to the stall.
    task automatic send_rx(input bit [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 11) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall !== 1'b0) @(posedge i_clk);
    endtask

    // Send a byte and queue whatever the deframer says it causes.
    task automatic offer(input bit [7:0] b, input bit counted, inout int sent);
        rx_result_q_t got;
        send_rx(b);
        deframe_step(b, got);
        foreach (got[i]) pending_items.push_back(got[i]);
        if (counted) sent++;
    endtask

    // Drop valid and wait for every expected item to come out.
    task automatic drain_wait();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_items.size() != 0) @(posedge i_clk);
    endtask

    // Result side stall: random idling, a quiet stretch, and one long hold
    // while a frame's items are waiting, so the block backs up into its input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_res_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && o_res_valid === 1'b1 && results_seen >= 30) begin
            i_res_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_res_stall <= !no_idle && ($urandom_range(0, 99) < 11);
        end
    end

    // Compare each taken result item with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        rx_result_t want;
        if (i_rst_n && o_res_valid === 1'b1 && !i_res_stall) begin
            results_seen++;
            if (pending_items.size() == 0) begin
                $error("result item with none expected: kind %0d, good %0d, type %0d",
                       o_item_kind, o_frame_good, o_packet_type);
                mismatches++;
            end else begin
                want = pending_items.pop_front();
                check_field("item_kind", want.kind, o_item_kind);
                check_field("frame_good", want.good, o_frame_good);
                check_field("packet_type", want.ptype, o_packet_type);
                check_field("data_type", want.dtype, o_data_type);
                check_field("data_length", want.dlen, o_data_length);
                check_field("payload_byte", want.pbyte, o_payload_byte);
                check_field("payload_index", want.pidx, o_payload_index);
                check_field("last_item", want.last, o_last_item);
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        rx_result_q_t got;
        byte_q_t      raw;
        byte_q_t      body;
        int           sent;
        int           frame_no;
        int unsigned  pick;
        int unsigned  npay;

        // Directed table. Bytes outside a frame come first, straight after
        // reset, and must be ignored.
        add_row(8'h55, ROW_QUIET, '0);
        add_row(8'hFF, ROW_QUIET, '0);
        add_row(FRAME_DELIM, ROW_QUIET, '0);                  // open
        add_row(FRAME_DELIM, ROW_QUIET, '0);                  // empty frame, stays open
        // Short frame: one decoded byte, the missing header reads as zero.
        add_row(8'h02, ROW_QUIET, '0);
        add_row(8'h01, ROW_QUIET, '0);
        add_row(FRAME_DELIM, ROW_STATUS, status_item(1'b0, 8'h01, 8'h00, 6'd0));
        // The closing delimiter did not reopen, so this byte is ignored.
        add_row(8'h07, ROW_QUIET, '0);
        // Bad COBS: the code byte runs past the stored bytes.
        add_row(FRAME_DELIM, ROW_QUIET, '0);
        add_row(8'h05, ROW_QUIET, '0);
        add_row(8'hAA, ROW_QUIET, '0);
        add_row(FRAME_DELIM, ROW_STATUS, status_item(1'b0, 8'h00, 8'h00, 6'd0));
        // Length too large: 255 saturates to 63 on the length field.
        add_row(FRAME_DELIM, ROW_QUIET, '0);
        body = {8'h06, 8'hFF, 8'h80, 8'hFF, 8'h11, 8'h22};
        foreach (body[j]) add_row(body[j], ROW_QUIET, '0);
        add_row(FRAME_DELIM, ROW_STATUS, status_item(1'b0, 8'hFF, 8'h80, 6'd63));
        // Good frame with zero and all-ones payload, checked by the deframer.
        add_row(FRAME_DELIM, ROW_PREDICT, '0);
        body = cobs_wrap(build_frame(8'h00, 8'hFF, 8'd2, {8'h00, 8'hFF}, 1'b0));
        foreach (body[j]) add_row(body[j], ROW_PREDICT, '0);
        add_row(FRAME_DELIM, ROW_PREDICT, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_rx(dir_rows[r].rx);
            deframe_step(dir_rows[r].rx, got);
            case (dir_rows[r].chk)
                ROW_PREDICT: begin
                    foreach (got[i]) pending_items.push_back(got[i]);
                end
                ROW_STATUS: begin
                    pending_items.push_back(dir_rows[r].want);
                end
                default: begin
                end
            endcase
        end
        drain_wait();

        // Random frames until enough bytes have gone into frames.
        sent     = 0;
        frame_no = 0;
        while (sent < ITEM_TARGET) begin
            no_idle = (frame_no >= 15 && frame_no < 30);
            // Pause the sender once mid-run until the result side is empty.
            if (frame_no == 8) drain_wait();
            pick = $urandom_range(0, 99);
            body = {};
            if (pick < 65) begin
                // Well-formed frame, now and then with a spoiled CRC.
                npay = $urandom_range(0, 9);
                if (npay == 9) npay = MAX_PAYLOAD;
                else if (npay == 8) npay = $urandom_range(7, MAX_PAYLOAD - 1);
                body = cobs_wrap(build_frame(8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 255)), 8'(npay),
                                             rand_payload(npay),
                                             $urandom_range(0, 9) == 0));
            end else if (pick < 75) begin
                // Declared length disagrees with the payload carried.
                npay = $urandom_range(0, 6);
                body = cobs_wrap(build_frame(8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 255)),
                                             8'($urandom_range(0, 255)),
                                             rand_payload(npay), 1'b0));
            end else if (pick < 85) begin
                // Overlong frame: more bytes than the store holds.
                repeat ($urandom_range(MAX_ENCODED + 1, MAX_ENCODED + 6)) begin
                    body.push_back(8'($urandom_range(1, 255)));
                end
            end else if (pick < 95) begin
                // Noise, or a good frame cut short.
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 10)) body.push_back(8'($urandom_range(1, 255)));
                end else begin
                    raw  = build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'd3, rand_payload(3), 1'b0);
                    body = cobs_wrap(raw);
                    repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
                end
            end else begin
                // Stray bytes between frames; the block ignores them.
                repeat ($urandom_range(1, 3)) offer(8'($urandom_range(1, 255)), 1'b0, sent);
            end

            offer(FRAME_DELIM, 1'b1, sent);
            if ($urandom_range(0, 7) == 0) offer(FRAME_DELIM, 1'b0, sent);
            if (body.size() != 0) begin
                foreach (body[j]) offer(body[j], 1'b1, sent);
                offer(FRAME_DELIM, 1'b1, sent);
            end
            frame_no++;
        end
        no_idle = 1'b0;

        // Wait out every expected item, then a tail for anything stray.
        drain_wait();
        repeat (MAX_ENCODED + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: cobs_crc_frame_receiver.f
design/ccfr_pkg.sv
design/ccfr_ctrl.sv
design/ccfr_dpath.sv
design/cobs_crc_frame_receiver.sv
verif/cobs_crc_frame_receiver_tb.sv
